// File: rtl/fftrk_pkg.sv
// Shared constants, register indexes and control types for the track image generator.
`default_nettype none

package fftrk_pkg;

    localparam int TRACK_BYTES = 11000;
    localparam int MAX_SECTORS = 32;

    localparam int POS_W  = $clog2(TRACK_BYTES);
    localparam int SLOT_W = $clog2(MAX_SECTORS);
    localparam int CNT_W  = $clog2(MAX_SECTORS + 1);
    localparam int OFF_W  = 11;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(TRACK_BYTES - 1);

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_DENSITY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_CODE        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTORS_PER_SIDE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERLEAVE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SECTOR     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_OFFSET_ON   = 3'd5;

    // image byte codes
    localparam logic [7:0] GAP_MFM    = 8'h4E;
    localparam logic [7:0] GAP_FM     = 8'hFF;
    localparam logic [7:0] SYNC_MARK  = 8'hF5;
    localparam logic [7:0] ID_MARK    = 8'hFE;
    localparam logic [7:0] CRC_REQ    = 8'hF7;
    localparam logic [7:0] DATA_MARK  = 8'hFB;
    localparam logic [7:0] FILL_BYTE  = 8'hE5;
    localparam logic [7:0] SYNC_ZERO  = 8'h00;

    typedef struct packed {
        logic accept;     // input beat taken this cycle
        logic rb_reduce;  // subtract sector count from skew step
        logic rb_step;    // one skew table placement or collision step
    } ctrl_cmd_t;

    typedef struct packed {
        logic step_ge_n;  // skew step not yet below sector count
        logic last_place; // this step places the final logical sector
    } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/fftrk_if.sv
// Handshake channel interfaces for request beats and image byte beats.
`default_nettype none

interface fftrk_in_if;
    logic       valid;
    logic       ready;
    logic       start_track;
    logic [7:0] track_number;
    logic       side_number;

    modport source (output valid, output start_track, output track_number,
                    output side_number, input ready);
    modport sink (input valid, input start_track, input track_number,
                  input side_number, output ready);
endinterface

interface fftrk_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] image_byte;
    logic       end_of_track;

    modport source (output valid, output image_byte, output end_of_track, input ready);
    modport sink (input valid, input image_byte, input end_of_track, output ready);
endinterface

`default_nettype wire

// File: rtl/fftrk_ctrl.sv
// Controller state machine: handshakes and skew table rebuild sequencing.
`default_nettype none

module fftrk_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_start,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output fftrk_pkg::ctrl_cmd_t       cmd,
    input  wire fftrk_pkg::dp_status_t status
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_REDUCE = 2'd1;
    localparam logic [1:0] ST_BUILD  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.accept     = accept;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // a start beat holds its byte back until the table is rebuilt
                    out_valid_next = !in_start;
                    if (in_start)
                        state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (status.step_ge_n)
                    cmd.rb_reduce = 1'b1;
                else
                    state_next = ST_BUILD;
            end
            ST_BUILD:
            begin
                cmd.rb_step = 1'b1;
                if (status.last_place)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/fftrk_dp.sv
// Datapath: configuration, track position counters, skew table and byte generator.
`default_nettype none

module fftrk_dp (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [fftrk_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [fftrk_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                                 in_start,
    input  wire logic [7:0]                           in_track,
    input  wire logic                                 in_side,
    input  wire fftrk_pkg::ctrl_cmd_t                 cmd,
    output fftrk_pkg::dp_status_t                     status,
    output logic [7:0]                                image_byte,
    output logic                                      end_of_track
);

    localparam int SW = fftrk_pkg::SLOT_W;
    localparam int CW = fftrk_pkg::CNT_W;
    localparam int OW = fftrk_pkg::OFF_W;
    localparam int PW = fftrk_pkg::POS_W;

    // configuration
    logic       dd_reg;
    logic [1:0] code_reg;
    logic [5:0] sps_reg;
    logic [4:0] ilv_reg;
    logic       first_reg;
    logic       soff_reg;

    // track position
    logic [PW-1:0] pos_reg;
    logic [CW-1:0] sidx_reg;
    logic [OW-1:0] off_reg;

    // skew table
    logic [SW-1:0] table_mem [fftrk_pkg::MAX_SECTORS];
    logic [fftrk_pkg::MAX_SECTORS-1:0] valid_reg;
    logic [4:0]    step_reg;
    logic [SW-1:0] slot_reg;
    logic [SW-1:0] logical_reg;

    logic [7:0] byte_reg;
    logic       eot_reg;

    logic [CW-1:0] n_cnt;
    logic [7:0]    gap;
    logic [OW-1:0] len, rec, idm, dm, g2end;
    logic [7:0]    fill;
    logic [PW-1:0] pos_eff;
    logic [CW-1:0] sidx_eff;
    logic [OW-1:0] off_eff;
    logic [7:0]    sec_num;
    logic [SW-1:0] entry;
    logic [7:0]    byte_val;
    logic          eot_val;
    logic [CW:0]   slot_inc;
    logic [CW:0]   slot_sum;
    logic [SW-1:0] slot_coll;
    logic [SW-1:0] slot_place;
    logic          taken;

    // clamp sector count into 1..MAX_SECTORS
    always_comb
    begin
        if (sps_reg == 6'd0)
            n_cnt = CW'(1);
        else if ({1'b0, sps_reg} > 7'(fftrk_pkg::MAX_SECTORS))
            n_cnt = CW'(fftrk_pkg::MAX_SECTORS);
        else
            n_cnt = CW'(sps_reg);
    end

    // record layout
    always_comb
    begin
        if (dd_reg)
        begin
            unique case (code_reg)
                2'd3:    gap = 8'd138;
                2'd2:    gap = 8'd40;
                default: gap = 8'd25;
            endcase
        end
        else
        begin
            gap = (code_reg == 2'd1) ? 8'd16 : 8'd27;
        end
        len   = OW'(11'd128 << code_reg);
        fill  = dd_reg ? fftrk_pkg::GAP_MFM : fftrk_pkg::GAP_FM;
        rec   = OW'(gap) + (dd_reg ? OW'(60) : OW'(31)) + len;
        idm   = OW'(gap) + (dd_reg ? OW'(15) : OW'(6));
        dm    = OW'(gap) + (dd_reg ? OW'(58) : OW'(29));
        g2end = OW'(gap) + (dd_reg ? OW'(43) : OW'(23));
    end

    // a start beat restarts the image at byte zero
    assign pos_eff  = in_start ? '0 : pos_reg;
    assign sidx_eff = in_start ? '0 : sidx_reg;
    assign off_eff  = in_start ? '0 : off_reg;

    assign entry = valid_reg[sidx_eff[SW-1:0]] ? table_mem[sidx_eff[SW-1:0]] : '0;

    always_comb
    begin
        sec_num = 8'(entry) + 8'(first_reg);
        if (soff_reg && in_side)
            sec_num = sec_num + 8'(n_cnt);
    end

    always_comb
    begin
        if (sidx_eff >= n_cnt)
            byte_val = fill;
        else if (off_eff < OW'(gap))
            byte_val = fill;
        else if (off_eff < idm)
            byte_val = (dd_reg && off_eff >= OW'(gap) + OW'(12)) ?
                       fftrk_pkg::SYNC_MARK : fftrk_pkg::SYNC_ZERO;
        else if (off_eff == idm)
            byte_val = fftrk_pkg::ID_MARK;
        else if (off_eff == idm + OW'(1))
            byte_val = in_track;
        else if (off_eff == idm + OW'(2))
            byte_val = 8'(in_side);
        else if (off_eff == idm + OW'(3))
            byte_val = sec_num;
        else if (off_eff == idm + OW'(4))
            byte_val = 8'(code_reg);
        else if (off_eff == idm + OW'(5))
            byte_val = fftrk_pkg::CRC_REQ;
        else if (off_eff < g2end)
            byte_val = fill;
        else if (off_eff < dm)
            byte_val = (dd_reg && off_eff >= OW'(gap) + OW'(55)) ?
                       fftrk_pkg::SYNC_MARK : fftrk_pkg::SYNC_ZERO;
        else if (off_eff == dm)
            byte_val = fftrk_pkg::DATA_MARK;
        else if (off_eff < dm + OW'(1) + len)
            byte_val = fftrk_pkg::FILL_BYTE;
        else if (off_eff == dm + OW'(1) + len)
            byte_val = fftrk_pkg::CRC_REQ;
        else
            byte_val = fill;
    end

    assign eot_val = (pos_eff >= fftrk_pkg::LAST_POS);

    // skew table placement arithmetic
    assign taken      = valid_reg[slot_reg];
    assign slot_inc   = (CW+1)'(slot_reg) + (CW+1)'(1);
    assign slot_coll  = (slot_inc >= (CW+1)'(n_cnt)) ? '0 : slot_inc[SW-1:0];
    assign slot_sum   = (CW+1)'(slot_reg) + (CW+1)'(step_reg);
    assign slot_place = (slot_sum >= (CW+1)'(n_cnt)) ?
                        SW'(slot_sum - (CW+1)'(n_cnt)) : slot_sum[SW-1:0];

    assign status.step_ge_n  = (CW'(step_reg) >= n_cnt);
    assign status.last_place = !taken && ((CW'(logical_reg) + CW'(1)) == n_cnt);

    assign image_byte   = byte_reg;
    assign end_of_track = eot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dd_reg    <= 1'b1;
            code_reg  <= 2'd1;
            sps_reg   <= 6'd16;
            ilv_reg   <= 5'd1;
            first_reg <= 1'b1;
            soff_reg  <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                fftrk_pkg::CFG_DOUBLE_DENSITY:   dd_reg    <= cfg_wdata[0];
                fftrk_pkg::CFG_SIZE_CODE:        code_reg  <= cfg_wdata[1:0];
                fftrk_pkg::CFG_SECTORS_PER_SIDE: sps_reg   <= cfg_wdata[5:0];
                fftrk_pkg::CFG_INTERLEAVE:       ilv_reg   <= cfg_wdata[4:0];
                fftrk_pkg::CFG_FIRST_SECTOR:     first_reg <= cfg_wdata[0];
                fftrk_pkg::CFG_SIDE_OFFSET_ON:   soff_reg  <= cfg_wdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            sidx_reg <= '0;
            off_reg  <= '0;
        end
        else if (cmd.accept)
        begin
            if (eot_val)
            begin
                pos_reg  <= '0;
                sidx_reg <= '0;
                off_reg  <= '0;
            end
            else
            begin
                pos_reg <= pos_eff + PW'(1);
                if (sidx_eff < n_cnt)
                begin
                    if ((off_eff + OW'(1)) >= rec)
                    begin
                        off_reg  <= '0;
                        sidx_reg <= sidx_eff + CW'(1);
                    end
                    else
                    begin
                        off_reg  <= off_eff + OW'(1);
                        sidx_reg <= sidx_eff;
                    end
                end
                else
                begin
                    off_reg  <= off_eff;
                    sidx_reg <= sidx_eff;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            byte_reg <= byte_val;
            eot_reg  <= eot_val;
        end
    end

    // rebuild control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            step_reg    <= '0;
            slot_reg    <= '0;
            logical_reg <= '0;
        end
        else if (cmd.accept && in_start)
        begin
            valid_reg   <= '0;
            step_reg    <= ilv_reg;
            slot_reg    <= '0;
            logical_reg <= '0;
        end
        else if (cmd.rb_reduce)
        begin
            step_reg <= step_reg - 5'(n_cnt);
        end
        else if (cmd.rb_step)
        begin
            if (taken)
            begin
                slot_reg <= slot_coll;
            end
            else
            begin
                valid_reg[slot_reg] <= 1'b1;
                logical_reg         <= logical_reg + SW'(1);
                slot_reg            <= slot_place;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rb_step && !taken)
            table_mem[slot_reg] <= logical_reg;
    end

endmodule

`default_nettype wire

// File: rtl/floppy_format_track_image.sv
// Top level of the floppy write-track image generator.
`default_nettype none

// Channel   Dir  Beat contents
// in_ch     in   start_track, track_number, side_number (one request per image byte)
// out_ch    out  image_byte, end_of_track (one byte per request)
// cfg_*     in   write enable, register index, write data (no read-back)
//
// An ordinary request is taken whenever the output register is free; a byte a cycle
// is sustained while the output side keeps taking beats, as the output register
// frees in the same cycle. A start_track request rebuilds the skew table in the
// sequencer: it first reduces the skew step below the sector count by repeated
// subtraction, then makes placement and collision steps (n placements plus collisions);
// no request is taken meanwhile and the start byte is offered when the table is done.
// Reset clears the track position, the table valid bits and the configuration to
// its defaults (MFM, 256-byte sectors, 16 sectors, skew 1, first sector 1).
module floppy_format_track_image (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    fftrk_in_if.sink                               in_ch,
    fftrk_out_if.source                            out_ch,
    input  wire logic                              cfg_wr_en,
    input  wire logic [fftrk_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [fftrk_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    fftrk_pkg::ctrl_cmd_t  cmd;
    fftrk_pkg::dp_status_t status;
    logic                  in_ready;
    logic                  out_valid;

    // sequencer: handshakes and rebuild stepping
    fftrk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_start  (in_ch.start_track),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // datapath: counters, skew table, byte generator and output register
    fftrk_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_start     (in_ch.start_track),
        .in_track     (in_ch.track_number),
        .in_side      (in_ch.side_number),
        .cmd          (cmd),
        .status       (status),
        .image_byte   (out_ch.image_byte),
        .end_of_track (out_ch.end_of_track)
    );

    assign in_ch.ready  = in_ready;
    assign out_ch.valid = out_valid;

endmodule

`default_nettype wire

// File: verif/floppy_format_track_image_checker.sv
// Checker for the track image generator: predicts each image beat and compares it.
`timescale 1ns / 100ps

module floppy_format_track_image_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    fftrk_in_if                                    req_ch,
    fftrk_out_if                                   img_ch,
    input  wire logic                              cfg_wr_en,
    input  wire logic [fftrk_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [fftrk_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                                     mismatches,
    output int                                     bytes_pending
);
    import fftrk_pkg::*;

    typedef struct packed {
        logic [7:0] image_byte;
        logic       end_of_track;
    } track_beat_t;

    // copy of the configuration registers
    logic       mfm;
    logic [1:0] size_code_r;
    logic [5:0] spt;
    logic [4:0] skew;
    logic       base;
    logic       side_ofs;

    // skew table and track position
    logic [4:0] skew_entry [MAX_SECTORS];
    logic       skew_valid [MAX_SECTORS];
    int         track_pos;
    int         rec_idx;
    int         rec_off;

    track_beat_t image_queue [$];

    function automatic int live_sectors();
        int n = spt;
        if (n < 1) n = 1;
        if (n > MAX_SECTORS) n = MAX_SECTORS;
        return n;
    endfunction

    function automatic int lead_gap();
        if (mfm) begin
            if (size_code_r == 2'd3) return 25 + 15 + 98;
            if (size_code_r == 2'd2) return 25 + 15;
            return 25;
        end
        return (size_code_r == 2'd1) ? 16 : 27;
    endfunction

    function automatic int record_len();
        return lead_gap() + (mfm ? 60 : 31) + (128 << size_code_r);
    endfunction

    // place logical sectors at skew steps, sliding past taken slots
    function automatic void rebuild_skew();
        int n;
        int slot;
        int logical;
        n = live_sectors();
        slot = 0;
        logical = 0;
        for (int i = 0; i < MAX_SECTORS; i++) skew_valid[i] = 1'b0;
        while (logical < n) begin
            if (skew_valid[slot]) begin
                slot = (slot + 1 >= n) ? 0 : slot + 1;
            end
            else begin
                skew_entry[slot] = 5'(logical);
                skew_valid[slot] = 1'b1;
                logical++;
                slot = (slot + skew) % n;
            end
        end
    endfunction

    function automatic logic [7:0] record_byte(int off, logic [7:0] trk, logic sd);
        int         gap;
        int         len;
        int         idm;
        int         dm;
        int         g2;
        int         num;
        logic [7:0] pad;
        gap = lead_gap();
        len = 128 << size_code_r;
        pad = mfm ? GAP_MFM : GAP_FM;
        idm = mfm ? gap + 15 : gap + 6;
        dm  = mfm ? gap + 58 : gap + 29;
        g2  = mfm ? 43 : 23;
        if (off < gap) return pad;
        if (off < idm) return (mfm && off >= gap + 12) ? SYNC_MARK : SYNC_ZERO;
        if (off == idm) return ID_MARK;
        if (off == idm + 1) return trk;
        if (off == idm + 2) return {7'd0, sd};
        if (off == idm + 3) begin
            num = skew_valid[rec_idx] ? int'(skew_entry[rec_idx]) : 0;
            num += base;
            if (side_ofs && sd) num += live_sectors();
            return 8'(num);
        end
        if (off == idm + 4) return {6'd0, size_code_r};
        if (off == idm + 5) return CRC_REQ;
        if (off < gap + g2) return pad;
        if (off < dm) return (mfm && off >= gap + 55) ? SYNC_MARK : SYNC_ZERO;
        if (off == dm) return DATA_MARK;
        if (off < dm + 1 + len) return FILL_BYTE;
        if (off == dm + 1 + len) return CRC_REQ;
        return pad;
    endfunction

    function automatic track_beat_t advance_track(logic st, logic [7:0] trk, logic sd);
        track_beat_t beat;
        int          n;
        int          rec;
        if (st) begin
            track_pos = 0;
            rec_idx = 0;
            rec_off = 0;
            rebuild_skew();
        end
        n = live_sectors();
        rec = record_len();
        beat.image_byte = (rec_idx < n) ? record_byte(rec_off, trk, sd)
                                        : (mfm ? GAP_MFM : GAP_FM);
        beat.end_of_track = (track_pos >= TRACK_BYTES - 1);
        if (beat.end_of_track) begin
            track_pos = 0;
            rec_idx = 0;
            rec_off = 0;
        end
        else begin
            track_pos++;
            if (rec_idx < n) begin
                if (rec_off + 1 >= rec) begin
                    rec_off = 0;
                    rec_idx++;
                end
                else begin
                    rec_off++;
                end
            end
        end
        return beat;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        track_beat_t want;
        if (!rst_n) begin
            mfm = 1'b1;
            size_code_r = 2'd1;
            spt = 6'd16;
            skew = 5'd1;
            base = 1'b1;
            side_ofs = 1'b0;
            for (int i = 0; i < MAX_SECTORS; i++) begin
                skew_entry[i] = 5'd0;
                skew_valid[i] = 1'b0;
            end
            track_pos = 0;
            rec_idx = 0;
            rec_off = 0;
            image_queue.delete();
            mismatches = 0;
            bytes_pending = 0;
        end
        else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_DOUBLE_DENSITY:   mfm = cfg_wdata[0];
                    CFG_SIZE_CODE:        size_code_r = cfg_wdata[1:0];
                    CFG_SECTORS_PER_SIDE: spt = cfg_wdata[5:0];
                    CFG_INTERLEAVE:       skew = cfg_wdata[4:0];
                    CFG_FIRST_SECTOR:     base = cfg_wdata[0];
                    CFG_SIDE_OFFSET_ON:   side_ofs = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (req_ch.valid && req_ch.ready)
                image_queue.push_back(advance_track(req_ch.start_track, req_ch.track_number,
                                                    req_ch.side_number));
            if (img_ch.valid && img_ch.ready) begin
                if (image_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: image beat %02h eot %0b with no request outstanding",
                                 $time, img_ch.image_byte, img_ch.end_of_track);
                end
                else begin
                    want = image_queue.pop_front();
                    if (want.image_byte !== img_ch.image_byte ||
                        want.end_of_track !== img_ch.end_of_track) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: image beat mismatch: expected %02h eot %0b, got %02h eot %0b",
                                     $time, want.image_byte, want.end_of_track,
                                     img_ch.image_byte, img_ch.end_of_track);
                    end
                end
            end
            bytes_pending = image_queue.size();
        end
    end

endmodule

// File: verif/floppy_format_track_image_tb.sv
// Testbench top for the track image generator: stimulus, register programming and verdict.
`timescale 1ns / 100ps

module floppy_format_track_image_tb;
    import fftrk_pkg::*;

    localparam int      CLK_PERIOD   = 10;
    localparam int      RANDOM_ITEMS = 1550;
    // the phase that runs a whole track and beyond, across the track end
    localparam int      FULL_TRACK_PHASE = 2;
    // slowest legal run is some 14.5k beats plus table rebuilds; allow several times that
    localparam longint  LIMIT_NS = 20_000_000;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    int                     mismatches;
    int                     bytes_pending;

    // receiver stall pattern: one window of ready bits at a time
    logic [31:0]            stall_pattern;
    logic [4:0]             stall_slot = 5'd0;

    // beats still to go in the current sender burst
    int                     burst_left = 0;

    fftrk_in_if  req_ch ();
    fftrk_out_if img_ch ();

    floppy_format_track_image dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (req_ch),
        .out_ch    (img_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    floppy_format_track_image_checker track_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_ch        (req_ch),
        .img_ch        (img_ch),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .bytes_pending (bytes_pending)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Receiver: pick a fresh stall pattern each time the slot counter wraps. Some
    // windows take every beat; the others stall at random, but every eighth slot is
    // forced ready so that no stall outlasts the gap to the next forced slot.
    always @(negedge clk)
    begin
        if (stall_slot == 5'd0) begin
            case ($urandom_range(0, 3))
                0:       stall_pattern = '1;
                1:       stall_pattern = $urandom | 32'h0101_0101;
                default: stall_pattern = ($urandom | $urandom) | 32'h0101_0101;
            endcase
        end
        img_ch.ready <= stall_pattern[stall_slot];
        stall_slot <= stall_slot + 5'd1;
    end

    // Offer one request beat and hold it until taken. Open a new burst, with
    // a random gap before it, whenever the last one has run out; a gap of zero
    // keeps valid high straight across the burst boundary.
    task automatic send_request(input logic st, input logic [7:0] trk, input logic sd);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        req_ch.valid        <= 1'b1;
        req_ch.start_track  <= st;
        req_ch.track_number <= trk;
        req_ch.side_number  <= sd;
        do @(posedge clk); while (!req_ch.ready);
        @(negedge clk);
    endtask

    // Drop valid and hold off until every image byte asked for has come back.
    // Always wait for the next falling edge before checking, so that valid is not
    // raised again in the step that lowered it.
    task automatic drain_requests();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        @(negedge clk);
        while (bytes_pending != 0) @(negedge clk);
    endtask

    // One register write per cycle; the caller lowers the write enable.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
    endtask

    // Favour the edges: zero and above the maximum are clamped by the block.
    function automatic logic [5:0] pick_sector_count();
        case ($urandom_range(0, 7))
            0:       return 6'd0;
            1:       return 6'd1;
            2:       return 6'd32;
            3:       return 6'd33;
            4:       return 6'd63;
            default: return 6'($urandom_range(1, 32));
        endcase
    endfunction

    function automatic logic [5:0] pick_skew();
        case ($urandom_range(0, 5))
            0:       return 6'd0;
            1:       return 6'd31;
            2:       return 6'($urandom_range(1, 3));
            default: return 6'($urandom_range(0, 31));
        endcase
    endfunction

    // Program the layout for one phase. Phase one sets every register to its
    // minimum, the full-track phase every register to its maximum; later
    // phases rewrite a random subset.
    task automatic choose_settings(input int phase_no);
        if (phase_no == 1) begin
            write_register(CFG_DOUBLE_DENSITY, 6'd0);
            write_register(CFG_SIZE_CODE, 6'd0);
            write_register(CFG_SECTORS_PER_SIDE, 6'd0);
            write_register(CFG_INTERLEAVE, 6'd0);
            write_register(CFG_FIRST_SECTOR, 6'd0);
            write_register(CFG_SIDE_OFFSET_ON, 6'd0);
        end
        else if (phase_no == FULL_TRACK_PHASE) begin
            // MFM with 1024-byte sectors: the tenth record runs past the track end
            write_register(CFG_DOUBLE_DENSITY, 6'd1);
            write_register(CFG_SIZE_CODE, 6'd3);
            write_register(CFG_SECTORS_PER_SIDE, 6'd63);
            write_register(CFG_INTERLEAVE, 6'd31);
            write_register(CFG_FIRST_SECTOR, 6'd1);
            write_register(CFG_SIDE_OFFSET_ON, 6'd1);
        end
        else begin
            if ($urandom_range(0, 1))
                write_register(CFG_DOUBLE_DENSITY, 6'($urandom_range(0, 1)));
            if ($urandom_range(0, 1))
                write_register(CFG_SIZE_CODE, 6'($urandom_range(0, 3)));
            if ($urandom_range(0, 1))
                write_register(CFG_SECTORS_PER_SIDE, pick_sector_count());
            if ($urandom_range(0, 1))
                write_register(CFG_INTERLEAVE, pick_skew());
            if ($urandom_range(0, 1))
                write_register(CFG_FIRST_SECTOR, 6'($urandom_range(0, 1)));
            if ($urandom_range(0, 1))
                write_register(CFG_SIDE_OFFSET_ON, 6'($urandom_range(0, 1)));
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Stop the run if the block wedges.
    initial
    begin
        #(LIMIT_NS);
        $display("floppy_format_track_image_tb: FAIL");
        $finish;
    end

    initial
    begin
        int         phase_no;
        int         random_sent;
        int         count;
        bit         noisy;
        bit         restart;
        logic       st;
        logic [7:0] trk;
        logic       sd;

        // hold every input at a known value through reset
        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_index           = CFG_DOUBLE_DENSITY;
        cfg_wdata           = '0;
        req_ch.valid        = 1'b0;
        req_ch.start_track  = 1'b0;
        req_ch.track_number = 8'd0;
        req_ch.side_number  = 1'b0;
        img_ch.ready        = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed opening: reset layout, no track start, so the skew table is
        // still empty when the first sector number goes out. Swing the track
        // and side fields between their extremes.
        for (int i = 0; i < 24; i++)
            send_request(1'b0, (i % 2 == 0) ? 8'h00 : 8'hFF, (i % 4 >= 2));

        // Random phases. Most are well formed: one start, then a run of bytes
        // for a fixed cylinder and surface. Some skip the start so that the new
        // layout lands in mid-track; a fifth are noise with fields changing
        // on every beat and the odd stray restart.
        random_sent = 0;
        phase_no = 0;
        while (random_sent < RANDOM_ITEMS || phase_no <= FULL_TRACK_PHASE) begin
            if (phase_no > 0) begin
                drain_requests();
                choose_settings(phase_no);
            end

            if (phase_no == FULL_TRACK_PHASE)
                count = TRACK_BYTES + $urandom_range(200, 1500);
            else if (phase_no == 0)
                count = $urandom_range(40, 150);
            else
                count = ($urandom_range(0, 5) == 0) ? $urandom_range(200, 400)
                                                     : $urandom_range(20, 160);

            noisy   = (phase_no > FULL_TRACK_PHASE) && ($urandom_range(0, 4) == 0);
            restart = (phase_no == FULL_TRACK_PHASE) ||
                      (phase_no > 0 && $urandom_range(0, 3) != 0);
            trk = (phase_no == 1) ? 8'h00 : (phase_no == FULL_TRACK_PHASE) ? 8'hFF
                                                                             : 8'($urandom);
            sd  = (phase_no == FULL_TRACK_PHASE) ? 1'b1 : 1'($urandom_range(0, 1));

            for (int k = 0; k < count; k++) begin
                // hold off in mid-stream once until the output side has caught up
                if (phase_no == FULL_TRACK_PHASE + 1 && k == count / 2)
                    drain_requests();
                st = (k == 0 && restart) || (noisy && $urandom_range(0, 63) == 0);
                if (noisy) begin
                    trk = 8'($urandom);
                    sd  = 1'($urandom_range(0, 1));
                end
                send_request(st, trk, sd);
            end

            if (phase_no != FULL_TRACK_PHASE)
                random_sent += count;
            phase_no++;
        end

        // let the last bytes drain, then give any stray beat time to show up
        drain_requests();
        repeat (32) @(negedge clk);

        if (mismatches == 0 && bytes_pending == 0)
            $display("floppy_format_track_image_tb: PASS");
        else
            $display("floppy_format_track_image_tb: FAIL");
        $finish;
    end

endmodule
